>>> rtl/acl_rule_pair_conflict_classifier_macros.svh
// Assertion macros used by the rule pair classifier checker.
`ifndef ACL_RULE_PAIR_CONFLICT_CLASSIFIER_MACROS_SVH
`define ACL_RULE_PAIR_CONFLICT_CLASSIFIER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ARPC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("arpc assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ARPC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("arpc assertion failed");

`endif

>>> rtl/arpc_pkg.sv
// Types, codes and relation functions for the rule pair classifier.
`default_nettype none

package arpc_pkg;

  typedef logic [2:0] rel_t;
  typedef logic [2:0] ctype_t;

  localparam rel_t REL_NONE       = 3'd0;
  localparam rel_t REL_EQUIV      = 3'd1;
  localparam rel_t REL_SUBSET     = 3'd2;
  localparam rel_t REL_SUPERSET   = 3'd3;
  localparam rel_t REL_INTERLEAVE = 3'd4;

  localparam ctype_t CT_NONE           = 3'd0;
  localparam ctype_t CT_SHADOWING      = 3'd1;
  localparam ctype_t CT_REDUNDANCY     = 3'd2;
  localparam ctype_t CT_GENERALIZATION = 3'd3;
  localparam ctype_t CT_CORRELATION    = 3'd4;
  localparam ctype_t CT_SUPERIMPOSING  = 3'd5;

  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_ANY  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_IPV4 = 8'd1;

  localparam logic [7:0] ANY_PROTO_RESET  = 8'd255;
  localparam logic [7:0] IPV4_PROTO_RESET = 8'd254;

  typedef struct packed {
    logic [7:0]  protocol;
    logic [63:0] src_ip;
    logic [63:0] dst_ip;
    logic [32:0] src_port;
    logic [32:0] dst_port;
    logic [1:0]  action;
  } rule_t;

  typedef struct packed {
    rel_t proto;
    rel_t src_ip;
    rel_t dst_ip;
    rel_t src_port;
    rel_t dst_port;
  } rel_set_t;

  function automatic rel_t range_rel(logic [31:0] ys, logic [31:0] ye,
                                     logic [31:0] xs, logic [31:0] xe);
    rel_t r;
    if (ye < xs || xe < ys) begin
      r = REL_NONE;
    end else if (ys == xs && ye == xe) begin
      r = REL_EQUIV;
    end else if (ys >= xs && ye <= xe) begin
      r = REL_SUBSET;
    end else if (ys <= xs && ye >= xe) begin
      r = REL_SUPERSET;
    end else begin
      r = REL_INTERLEAVE;
    end
    return r;
  endfunction

  function automatic rel_t ip_rel(logic [63:0] y, logic [63:0] x);
    return range_rel(y[63:32], y[31:0], x[63:32], x[31:0]);
  endfunction

  function automatic rel_t port_rel(logic [32:0] y, logic [32:0] x);
    rel_t       r;
    rel_t       q;
    logic [1:0] neg;
    r   = range_rel({16'd0, y[31:16]}, {16'd0, y[15:0]},
                    {16'd0, x[31:16]}, {16'd0, x[15:0]});
    neg = {y[32], x[32]};
    unique case (r)
      REL_NONE: begin
        unique case (neg)
          2'b00:   q = REL_NONE;
          2'b10:   q = REL_SUPERSET;
          2'b01:   q = REL_SUBSET;
          default: q = REL_INTERLEAVE;
        endcase
      end
      REL_EQUIV: begin
        q = (y[32] == x[32]) ? REL_EQUIV : REL_NONE;
      end
      REL_SUBSET: begin
        unique case (neg)
          2'b00:   q = REL_SUBSET;
          2'b10:   q = REL_INTERLEAVE;
          2'b01:   q = REL_NONE;
          default: q = REL_SUPERSET;
        endcase
      end
      REL_SUPERSET: begin
        unique case (neg)
          2'b00:   q = REL_SUPERSET;
          2'b10:   q = REL_NONE;
          2'b01:   q = REL_INTERLEAVE;
          default: q = REL_SUBSET;
        endcase
      end
      default: q = REL_INTERLEAVE;
    endcase
    return q;
  endfunction

  function automatic rel_t proto_rel(logic [7:0] y, logic [7:0] x,
                                     logic [7:0] any_code, logic [7:0] ipv4_code);
    rel_t r;
    priority if (y == x)         r = REL_EQUIV;
    else if (y == any_code)      r = REL_SUPERSET;
    else if (x == any_code)      r = REL_SUBSET;
    else if (y == ipv4_code)     r = REL_SUPERSET;
    else if (x == ipv4_code)     r = REL_SUBSET;
    else                         r = REL_NONE;
    return r;
  endfunction

  function automatic rel_t fold_rel(rel_t g, rel_t p);
    rel_t r;
    if (g == REL_NONE || p == REL_NONE) begin
      r = REL_NONE;
    end else if (p == REL_EQUIV) begin
      r = g;
    end else if (p == REL_SUBSET) begin
      r = (g == REL_EQUIV || g == REL_SUBSET) ? REL_SUBSET : REL_INTERLEAVE;
    end else if (p == REL_SUPERSET) begin
      r = (g == REL_EQUIV || g == REL_SUPERSET) ? REL_SUPERSET : REL_INTERLEAVE;
    end else begin
      r = REL_INTERLEAVE;
    end
    return r;
  endfunction

  function automatic ctype_t conflict_of(rel_t rel, logic same);
    ctype_t c;
    if (rel == REL_EQUIV || rel == REL_SUBSET) begin
      c = same ? CT_REDUNDANCY : CT_SHADOWING;
    end else if (rel == REL_SUPERSET) begin
      c = same ? CT_REDUNDANCY : CT_GENERALIZATION;
    end else if (rel == REL_INTERLEAVE) begin
      c = same ? CT_SUPERIMPOSING : CT_CORRELATION;
    end else begin
      c = CT_NONE;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> rtl/acl_rule_pair_conflict_classifier.sv
// Top level of the access-list rule pair conflict classifier.
//
// Request channel: drive the Y (later) and X (earlier) rule fields on in_* and
// pulse start; a request is taken at each rising edge with start high and busy
// low. busy is high only while rst_n is low, so one request per cycle is taken.
// Result channel: out_valid is high for exactly one cycle with the relations
// and conflict type of one request; results come out in request order.
// A request passes the input register, then the result register, before its
// result can be taken. Throughput: 1 request per cycle.
// The receiver cannot stall; a result not taken in its cycle is gone.
// Configuration: cfg_ready is always high; index 0 sets the any-protocol code,
// index 1 the IPv4 wildcard code, other indexes are dropped. Write only while
// no request is in flight.
// Reset (synchronous, rst_n low): flushes both pipeline valids and restores
// the protocol codes to 255 and 254.
`default_nettype none

module acl_rule_pair_conflict_classifier (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [7:0]                     in_y_protocol,
  input  logic [63:0]                    in_y_src_ip_range,
  input  logic [63:0]                    in_y_dst_ip_range,
  input  logic [32:0]                    in_y_src_port,
  input  logic [32:0]                    in_y_dst_port,
  input  logic [1:0]                     in_y_action,
  input  logic [7:0]                     in_x_protocol,
  input  logic [63:0]                    in_x_src_ip_range,
  input  logic [63:0]                    in_x_dst_ip_range,
  input  logic [32:0]                    in_x_src_port,
  input  logic [32:0]                    in_x_dst_port,
  input  logic [1:0]                     in_x_action,
  output logic                           out_valid,
  output logic [2:0]                     out_conflict_type,
  output logic                           out_is_conflict,
  output logic [2:0]                     out_combined_relation,
  output logic [2:0]                     out_protocol_relation,
  output logic [2:0]                     out_src_ip_relation,
  output logic [2:0]                     out_dst_ip_relation,
  output logic [2:0]                     out_src_port_relation,
  output logic [2:0]                     out_dst_port_relation,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [arpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data
);

  logic               accept;
  logic               in_vld_r;
  arpc_pkg::rule_t    y_r;
  arpc_pkg::rule_t    x_r;
  logic [7:0]         any_code_r;
  logic [7:0]         ipv4_code_r;
  arpc_pkg::rel_set_t rels;
  arpc_pkg::rel_t     combined;
  arpc_pkg::ctype_t   conflict;
  logic               out_vld_r;
  arpc_pkg::rel_set_t rels_r;
  arpc_pkg::rel_t     combined_r;
  arpc_pkg::ctype_t   conflict_r;

  assign busy      = ~rst_n;
  assign cfg_ready = 1'b1;
  assign accept    = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      any_code_r  <= arpc_pkg::ANY_PROTO_RESET;
      ipv4_code_r <= arpc_pkg::IPV4_PROTO_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == arpc_pkg::CFG_IDX_ANY) begin
        any_code_r <= cfg_data;
      end else if (cfg_index == arpc_pkg::CFG_IDX_IPV4) begin
        ipv4_code_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= accept;
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      y_r.protocol <= in_y_protocol;
      y_r.src_ip   <= in_y_src_ip_range;
      y_r.dst_ip   <= in_y_dst_ip_range;
      y_r.src_port <= in_y_src_port;
      y_r.dst_port <= in_y_dst_port;
      y_r.action   <= in_y_action;
      x_r.protocol <= in_x_protocol;
      x_r.src_ip   <= in_x_src_ip_range;
      x_r.dst_ip   <= in_x_dst_ip_range;
      x_r.src_port <= in_x_src_port;
      x_r.dst_port <= in_x_dst_port;
      x_r.action   <= in_x_action;
    end
  end

  arpc_rel_unit u_rel (
    .y_rule    (y_r),
    .x_rule    (x_r),
    .any_code  (any_code_r),
    .ipv4_code (ipv4_code_r),
    .rels      (rels)
  );

  arpc_fold_unit u_fold (
    .rels        (rels),
    .same_action (y_r.action == x_r.action),
    .combined    (combined),
    .conflict    (conflict)
  );

  always_ff @(posedge clk) begin
    if (in_vld_r) begin
      rels_r     <= rels;
      combined_r <= combined;
      conflict_r <= conflict;
    end
  end

  assign out_valid             = out_vld_r;
  assign out_conflict_type     = conflict_r;
  assign out_is_conflict       = (conflict_r != arpc_pkg::CT_NONE);
  assign out_combined_relation = combined_r;
  assign out_protocol_relation = rels_r.proto;
  assign out_src_ip_relation   = rels_r.src_ip;
  assign out_dst_ip_relation   = rels_r.dst_ip;
  assign out_src_port_relation = rels_r.src_port;
  assign out_dst_port_relation = rels_r.dst_port;

endmodule

`default_nettype wire

>>> rtl/arpc_rel_unit.sv
// Per-dimension relation of rule Y to rule X.
`default_nettype none

module arpc_rel_unit (
  input  arpc_pkg::rule_t    y_rule,
  input  arpc_pkg::rule_t    x_rule,
  input  logic [7:0]         any_code,
  input  logic [7:0]         ipv4_code,
  output arpc_pkg::rel_set_t rels
);

  always_comb begin
    rels.proto    = arpc_pkg::proto_rel(y_rule.protocol, x_rule.protocol,
                                        any_code, ipv4_code);
    rels.src_ip   = arpc_pkg::ip_rel(y_rule.src_ip, x_rule.src_ip);
    rels.dst_ip   = arpc_pkg::ip_rel(y_rule.dst_ip, x_rule.dst_ip);
    rels.src_port = arpc_pkg::port_rel(y_rule.src_port, x_rule.src_port);
    rels.dst_port = arpc_pkg::port_rel(y_rule.dst_port, x_rule.dst_port);
  end

endmodule

`default_nettype wire

>>> rtl/arpc_fold_unit.sv
// Folds the dimension relations and picks the conflict type.
`default_nettype none

module arpc_fold_unit (
  input  arpc_pkg::rel_set_t rels,
  input  logic               same_action,
  output arpc_pkg::rel_t     combined,
  output arpc_pkg::ctype_t   conflict
);

  arpc_pkg::rel_t c0, c1, c2, c3;

  always_comb begin
    c0       = arpc_pkg::fold_rel(arpc_pkg::REL_EQUIV, rels.proto);
    c1       = arpc_pkg::fold_rel(c0, rels.src_ip);
    c2       = arpc_pkg::fold_rel(c1, rels.dst_ip);
    c3       = arpc_pkg::fold_rel(c2, rels.src_port);
    combined = arpc_pkg::fold_rel(c3, rels.dst_port);
    conflict = arpc_pkg::conflict_of(combined, same_action);
  end

endmodule

`default_nettype wire

>>> rtl/arpc_checker.sv
// Port-level checker for the rule pair classifier, bound to the top level.
`default_nettype none

`include "acl_rule_pair_conflict_classifier_macros.svh"

module arpc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic [2:0] out_conflict_type,
  input logic       out_is_conflict,
  input logic [2:0] out_combined_relation,
  input logic [2:0] out_protocol_relation,
  input logic [2:0] out_src_ip_relation,
  input logic [2:0] out_dst_ip_relation,
  input logic [2:0] out_src_port_relation,
  input logic [2:0] out_dst_port_relation
);

  logic req_d1;
  logic any_none;

  assign any_none = (out_protocol_relation == arpc_pkg::REL_NONE) ||
                    (out_src_ip_relation   == arpc_pkg::REL_NONE) ||
                    (out_dst_ip_relation   == arpc_pkg::REL_NONE) ||
                    (out_src_port_relation == arpc_pkg::REL_NONE) ||
                    (out_dst_port_relation == arpc_pkg::REL_NONE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_d1 <= 1'b0;
    end else begin
      req_d1 <= start & ~busy;
    end
  end

  `ARPC_ASSERT_NEXT(a_req_gives_result, req_d1, out_valid)
  `ARPC_ASSERT_SAME(a_result_has_req, out_valid, $past(req_d1))
  `ARPC_ASSERT_SAME(a_flag_matches, out_valid, out_is_conflict == (out_conflict_type != arpc_pkg::CT_NONE))
  `ARPC_ASSERT_SAME(a_none_dominates, out_valid && any_none, out_combined_relation == arpc_pkg::REL_NONE)
  `ARPC_ASSERT_SAME(a_disjoint_no_conflict, out_valid && out_combined_relation == arpc_pkg::REL_NONE, out_conflict_type == arpc_pkg::CT_NONE)

endmodule

bind acl_rule_pair_conflict_classifier arpc_checker u_arpc_checker (.*);

`default_nettype wire
